// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/ynsr_pkg.sv =====
package ynsr_pkg;

    localparam int CFG_W     = 13;
    localparam int PIX_W     = 8;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int IN_DW     = 4 * PIX_W;
    localparam int OUT_DW    = 3 * PIX_W;
    localparam int OUT_UW    = 2;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_DST_W = 2'd2,
        REG_DST_H = 2'd3
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_SRC_W = 13'd1920;
    localparam logic [CFG_W-1:0] RST_SRC_H = 13'd1080;
    localparam logic [CFG_W-1:0] RST_DST_W = 13'd1408;
    localparam logic [CFG_W-1:0] RST_DST_H = 13'd768;

    // fixed-point color coefficients, 20 fractional bits
    localparam int                 C_SHIFT = 20;
    localparam logic signed [22:0] C_RV    = 23'sd1475871;
    localparam logic signed [22:0] C_GV    = 23'sd751724;
    localparam logic signed [22:0] C_GU    = 23'sd362283;
    localparam logic signed [22:0] C_BU    = 23'sd1865417;
    localparam logic signed [31:0] C_HALF  = 32'sd524288;
    localparam logic signed [8:0]  C_BIAS  = 9'sd128;

    typedef struct packed {
        logic [CFG_W-1:0] src_w;
        logic [CFG_W-1:0] src_h;
        logic [CFG_W-1:0] dst_w;
        logic [CFG_W-1:0] dst_h;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] y0;
        logic [PIX_W-1:0] y1;
        logic             hit0;
        logic             hit1;
        logic             eor0;
        logic             eof0;
        logic             eor1;
        logic             eof1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // floor by 2^20, then saturate to a byte
    function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [31:0] s);
        logic [31-C_SHIFT:0] q;
        q = s[31:C_SHIFT];
        if (q[31-C_SHIFT]) begin
            return '0;
        end else if (|q[30-C_SHIFT:PIX_W]) begin
            return '1;
        end
        return q[PIX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/uyvy_nearest_scale_to_rgb.sv =====
// A kept pixel passes the queue, the color product register and the output register.
// Throughput: one item per cycle while items keep at most one pixel and the output is ready;
// the color pipeline emits one pixel per cycle and pops a two-pixel item with its second.
// A 4-entry queue sits between position tracking and color conversion.
// Reset (i_rst_n low, synchronous): registers 1920/1080/1408/768, frame restarts.
// Any register write also restarts the frame.
`include "assert_macros.svh"

module uyvy_nearest_scale_to_rgb
    import ynsr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,

    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_DW-1:0]  i_s_axis_tdata,   // chroma_u, luma_even, chroma_v, luma_odd

    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata,   // red, green, blue
    output logic              o_m_axis_tlast,   // end_of_row
    output logic [OUT_UW-1:0] o_m_axis_tuser    // end_of_frame, last_of_item
);

    t_cfg       r_cfg;
    logic       cfg_wr;
    t_reg_idx   reg_idx;
    logic       w_push;
    logic       w_pop;
    t_entry     w_entry;
    t_entry     w_head;
    t_fifo_stat w_fstat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w <= RST_SRC_W;
            r_cfg.src_h <= RST_SRC_H;
            r_cfg.dst_w <= RST_DST_W;
            r_cfg.dst_h <= RST_DST_H;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SRC_W: r_cfg.src_w <= pwdata[CFG_W-1:0];
                REG_SRC_H: r_cfg.src_h <= pwdata[CFG_W-1:0];
                REG_DST_W: r_cfg.dst_w <= pwdata[CFG_W-1:0];
                REG_DST_H: r_cfg.dst_h <= pwdata[CFG_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SRC_W: prdata = APB_DW'(r_cfg.src_w);
            REG_SRC_H: prdata = APB_DW'(r_cfg.src_h);
            REG_DST_W: prdata = APB_DW'(r_cfg.dst_w);
            REG_DST_H: prdata = APB_DW'(r_cfg.dst_h);
            default:   prdata = '0;
        endcase
    end

    ynsr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_restart      (cfg_wr),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_s_axis_tready(o_s_axis_tready),
        .i_fifo_stat    (w_fstat),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    ynsr_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_entry),
        .i_pop  (w_pop),
        .o_data (w_head),
        .o_stat (w_fstat)
    );

    ynsr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_fifo_stat    (w_fstat),
        .o_pop          (w_pop),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    `ASSERT_CHK(a_push_has_room, i_clk, i_rst_n, w_push |-> !w_fstat.full)
    `ASSERT_NEVER(a_pop_nonempty, i_clk, i_rst_n, w_pop && w_fstat.empty)
    `ASSERT_CHK(a_eof_ends_row, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
    `ASSERT_CHK(a_push_then_data, i_clk, i_rst_n, w_push |=> !w_fstat.empty)

endmodule

// ===== hw/rtl/ynsr_fifo.sv =====
module ynsr_fifo
    import ynsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_entry     i_data,
    input  logic       i_pop,
    output t_entry     o_data,
    output t_fifo_stat o_stat
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_entry        r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;

    assign full    = (r_cnt == CW'(FIFO_DEPTH));
    assign empty   = (r_cnt == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/ynsr_front.sv =====
module ynsr_front
    import ynsr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_restart,
    input  logic             i_s_axis_tvalid,
    input  logic [IN_DW-1:0] i_s_axis_tdata,   // u, y0, v, y1
    output logic             o_s_axis_tready,
    input  t_fifo_stat       i_fifo_stat,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int EW = CB + 3;
    localparam int XW = (DW > CFG_W) ? DW : CFG_W;
    localparam logic [XW-1:0] MAXDIM = XW'(1) << CB;

    logic [CB-1:0] r_src_col;
    logic [CB-1:0] r_src_row;
    logic [EW-1:0] r_ec;
    logic [EW-1:0] r_er;
    logic          r_cdone;
    logic          r_rdone;
    logic [CB-1:0] r_dcol;
    logic [CB-1:0] r_drow;

    logic [XW-1:0] sw_x, sh_x, dw_x, dh_x;
    logic [DW-1:0] eff_sw, eff_sh, eff_dw, eff_dh;
    logic [DW-1:0] dw_m1, dh_m1;
    logic [EW-1:0] tw_sw, tw_sh, tw_dw, tw_dh;

    logic          accept;
    logic          ls, fs;
    logic [EW-1:0] ec, ec1, ec2, er;
    logic          cdone, rdone;
    logic [CB-1:0] dcol, dcol1, dcol2, drow;
    logic          row_hit, last_row;
    logic          hit0, hit1, eor0, eor1, eof0, eof1, eor, eof;
    logic          line_end, frame_end;

    // saturate the register values into a usable geometry
    always_comb begin
        sw_x = XW'(i_cfg.src_w);
        if (sw_x < XW'(2)) sw_x = XW'(2);
        if (sw_x > MAXDIM) sw_x = MAXDIM;
        sw_x[0] = 1'b0;
        sh_x = XW'(i_cfg.src_h);
        if (sh_x < XW'(1)) sh_x = XW'(1);
        if (sh_x > MAXDIM) sh_x = MAXDIM;
        dw_x = XW'(i_cfg.dst_w);
        if (dw_x < XW'(1)) dw_x = XW'(1);
        if (dw_x > sw_x) dw_x = sw_x;
        dh_x = XW'(i_cfg.dst_h);
        if (dh_x < XW'(1)) dh_x = XW'(1);
        if (dh_x > sh_x) dh_x = sh_x;
    end

    assign eff_sw = sw_x[DW-1:0];
    assign eff_sh = sh_x[DW-1:0];
    assign eff_dw = dw_x[DW-1:0];
    assign eff_dh = dh_x[DW-1:0];
    assign dw_m1  = eff_dw - DW'(1);
    assign dh_m1  = eff_dh - DW'(1);
    assign tw_sw  = EW'({eff_sw, 1'b0});
    assign tw_sh  = EW'({eff_sh, 1'b0});
    assign tw_dw  = EW'({eff_dw, 1'b0});
    assign tw_dh  = EW'({eff_dh, 1'b0});

    assign o_s_axis_tready = !i_fifo_stat.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // error terms: column x is a pick while ec < 2*dw, row likewise
    always_comb begin
        ls    = (r_src_col == '0);
        fs    = ls && (r_src_row == '0);
        ec    = ls ? EW'(eff_dw) : r_ec;
        cdone = ls ? 1'b0 : r_cdone;
        dcol  = ls ? '0 : r_dcol;
        er    = fs ? EW'(eff_dh) : r_er;
        rdone = fs ? 1'b0 : r_rdone;
        drow  = fs ? '0 : r_drow;

        row_hit  = !rdone && (er < tw_dh);
        last_row = (DW'(drow) == dh_m1);

        hit0  = row_hit && !cdone && (ec < tw_dw);
        eor0  = hit0 && (DW'(dcol) == dw_m1);
        eof0  = eor0 && last_row;
        ec1   = ec - tw_dw + (hit0 ? tw_sw : '0);
        dcol1 = dcol + CB'(hit0);

        hit1  = row_hit && !cdone && !eor0 && (ec1 < tw_dw);
        eor1  = hit1 && (DW'(dcol1) == dw_m1);
        eof1  = eor1 && last_row;
        ec2   = ec1 - tw_dw + (hit1 ? tw_sw : '0);
        dcol2 = dcol1 + CB'(hit1);

        eor = eor0 || eor1;
        eof = eof0 || eof1;

        line_end  = (DW'(r_src_col) + DW'(2)) >= eff_sw;
        frame_end = (DW'(r_src_row) + DW'(1)) >= eff_sh;
    end

    assign o_push       = accept && (hit0 || hit1);
    assign o_entry.u    = i_s_axis_tdata[PIX_W-1:0];
    assign o_entry.y0   = i_s_axis_tdata[2*PIX_W-1:PIX_W];
    assign o_entry.v    = i_s_axis_tdata[3*PIX_W-1:2*PIX_W];
    assign o_entry.y1   = i_s_axis_tdata[4*PIX_W-1:3*PIX_W];
    assign o_entry.hit0 = hit0;
    assign o_entry.hit1 = hit1;
    assign o_entry.eor0 = eor0;
    assign o_entry.eof0 = eof0;
    assign o_entry.eor1 = eor1;
    assign o_entry.eof1 = eof1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_ec      <= '0;
            r_er      <= '0;
            r_cdone   <= 1'b0;
            r_rdone   <= 1'b0;
            r_dcol    <= '0;
            r_drow    <= '0;
        end else if (accept) begin
            r_src_col <= line_end ? '0 : r_src_col + CB'(2);
            if (line_end) begin
                r_src_row <= frame_end ? '0 : r_src_row + CB'(1);
                r_er      <= er - tw_dh + (row_hit ? tw_sh : '0);
            end else begin
                r_er      <= er;
            end
            r_ec    <= ec2;
            r_cdone <= cdone || eor;
            r_dcol  <= dcol2;
            r_rdone <= rdone || eof;
            r_drow  <= eor ? (eof ? '0 : drow + CB'(1)) : drow;
        end
    end

endmodule

// ===== hw/rtl/ynsr_back.sv =====
module ynsr_back
    import ynsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_entry            i_head,
    input  t_fifo_stat        i_fifo_stat,
    output logic              o_pop,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata,   // red, green, blue
    output logic              o_m_axis_tlast,   // end_of_row
    output logic [OUT_UW-1:0] o_m_axis_tuser    // end_of_frame, last_of_item
);

    logic                    r_sub;
    logic                    r_s1_v;
    logic [PIX_W-1:0]        r_s1_y;
    logic signed [31:0]      r_pr, r_pgv, r_pgu, r_pbu;
    logic                    r_s1_eor, r_s1_eof, r_s1_last;
    logic                    r_out_v;
    logic [OUT_DW-1:0]       r_out_data;
    logic                    r_out_last;
    logic [OUT_UW-1:0]       r_out_user;

    logic                    en;
    logic                    take;
    logic                    use0;
    logic                    last;
    logic [PIX_W-1:0]        y_sel;
    logic signed [8:0]       du, dv;
    logic signed [31:0]      yy, sum_r, sum_g, sum_b;

    assign en    = !r_out_v || i_m_axis_tready;
    assign take  = en && !i_fifo_stat.empty;
    assign use0  = i_head.hit0 && !r_sub;
    assign last  = use0 ? !i_head.hit1 : 1'b1;
    assign y_sel = use0 ? i_head.y0 : i_head.y1;
    assign o_pop = take && last;

    assign du = $signed({1'b0, i_head.u}) - C_BIAS;
    assign dv = $signed({1'b0, i_head.v}) - C_BIAS;

    assign yy    = $signed(32'(r_s1_y) << C_SHIFT);
    assign sum_r = yy + r_pr + C_HALF;
    assign sum_g = yy - r_pgv - r_pgu + C_HALF;
    assign sum_b = yy + r_pbu + C_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 1'b0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (take) begin
                r_sub <= !last;
            end
            if (en) begin
                r_s1_v  <= take;
                r_out_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_y    <= y_sel;
            r_pr      <= 32'(C_RV * dv);
            r_pgv     <= 32'(C_GV * dv);
            r_pgu     <= 32'(C_GU * du);
            r_pbu     <= 32'(C_BU * du);
            r_s1_eor  <= use0 ? i_head.eor0 : i_head.eor1;
            r_s1_eof  <= use0 ? i_head.eof0 : i_head.eof1;
            r_s1_last <= last;
        end
        if (en) begin
            r_out_data <= {clamp_byte(sum_b), clamp_byte(sum_g), clamp_byte(sum_r)};
            r_out_last <= r_s1_eor;
            r_out_user <= {r_s1_last, r_s1_eof};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule
